@@ rtl/sidta_pkg.sv @@
// Shared constants and types for the signed integer to decimal ASCII unit.
// No dependencies; every other file in rtl uses it by scoped name.
`default_nettype none

package sidta_pkg;

  // Widths of the input value and the digit buffer.
  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 10;
  localparam int DIGIT_W     = 4;
  localparam int IDX_W       = $clog2(MAX_DIGITS);
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);

  // Division by ten as a multiply by a rounded-up reciprocal and a shift.
  // Exact for every magnitude below 2^32.
  localparam logic [VALUE_WIDTH-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int                     RECIP_SHIFT = 35;
  localparam int                     PROD_W      = 2 * VALUE_WIDTH;
  localparam int                     QUOT_W      = PROD_W - RECIP_SHIFT;

  // ASCII codes that the unit emits.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // One character word on the output channel.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_word_t;

endpackage

`default_nettype wire

@@ rtl/sidta_div10.sv @@
// Shared divide-by-ten unit: one multiplier that peels off one decimal digit
// per step, least significant first. Depends on sidta_pkg.
`default_nettype none

module sidta_div10 (
  input  wire logic                                clk,
  input  wire logic                                start,
  input  wire logic [sidta_pkg::VALUE_WIDTH-1:0]   mag,
  input  wire logic                                prime,
  input  wire logic                                step,
  output logic      [sidta_pkg::DIGIT_W-1:0]       digit,
  output logic                                     quot_zero
);

  logic [sidta_pkg::VALUE_WIDTH-1:0] cur;
  logic [sidta_pkg::PROD_W-1:0]      prod;
  logic [sidta_pkg::VALUE_WIDTH-1:0] quot;
  logic [sidta_pkg::VALUE_WIDTH-1:0] mul_in;
  logic [sidta_pkg::DIGIT_W-1:0]     quot_lo;
  logic [sidta_pkg::DIGIT_W-1:0]     ten_quot_lo;

  // Quotient of the current value by ten, taken from the registered product.
  assign quot = sidta_pkg::VALUE_WIDTH'(prod[sidta_pkg::PROD_W-1:sidta_pkg::RECIP_SHIFT]);
  assign quot_zero = (quot == '0);

  // The remainder is below ten, so only the low four bits of cur - 10*q matter.
  assign quot_lo     = quot[sidta_pkg::DIGIT_W-1:0];
  assign ten_quot_lo = sidta_pkg::DIGIT_W'((quot_lo << 3) + (quot_lo << 1));
  assign digit       = cur[sidta_pkg::DIGIT_W-1:0] - ten_quot_lo;

  // The single multiplier works on the new value, or on the quotient when stepping.
  assign mul_in = step ? quot : cur;

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= mag;
    end else if (step) begin
      cur <= quot;
    end
    if (prime || step) begin
      prod <= mul_in * sidta_pkg::RECIP_TEN;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sidta_out_reg.sv @@
// Output register for the character channel; it holds a word until taken.
// Depends on sidta_pkg.
`default_nettype none

module sidta_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire sidta_pkg::char_word_t word,
  output logic                       can_load,
  output logic                       char_valid,
  input  wire logic                  char_ready,
  output logic [7:0]                 char_code,
  output logic                       last_char
);

  sidta_pkg::char_word_t hold;

  // A new word may enter when the register is empty or its word leaves now.
  assign can_load  = !char_valid || char_ready;
  assign char_code = hold.char_code;
  assign last_char = hold.last_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (load) begin
      char_valid <= 1'b1;
    end else if (char_ready) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= word;
    end
  end

endmodule

`default_nettype wire

@@ rtl/signed_int_to_decimal_ascii_unit.sv @@
// Top level of the signed integer to decimal ASCII unit: sequencer, digit
// buffer, divide-by-ten unit and output register. Depends on sidta_pkg.
//
// Usage:
//   The value channel (value_valid, value_ready, value) takes one signed
//   32-bit integer per word. The char channel (char_valid, char_ready,
//   char_code, last_char) returns its decimal text, one ASCII character per
//   word: a '-' first for a negative value, then the digits, most significant
//   first, with no leading zeros. Zero prints as one '0'; the most negative
//   value prints 2147483648. last_char marks the final word of each number.
//   Timing: value_ready is high only while the unit is idle. After a word is
//   taken, the magnitude is loaded, the multiplier is primed, then the digits
//   run one digit per cycle through the shared divide-by-ten multiplier, then
//   the characters move one at a time into the output register. The first
//   character is shown only after every digit has been extracted.
//   A stalled receiver holds the current character in the output register and
//   pauses the emission; nothing is lost. Synchronous reset returns the unit
//   to idle with the output channel empty.
`default_nettype none

module signed_int_to_decimal_ascii_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              value_valid,
  output logic                                   value_ready,
  input  wire logic signed [sidta_pkg::VALUE_WIDTH-1:0] value,
  output logic                                   char_valid,
  input  wire logic                              char_ready,
  output logic [7:0]                             char_code,
  output logic                                   last_char
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic                              accept;
  logic [sidta_pkg::VALUE_WIDTH-1:0] value_u;
  logic [sidta_pkg::VALUE_WIDTH-1:0] mag;
  logic [sidta_pkg::DIGIT_W-1:0]     digit;
  logic                              quot_zero;
  logic [sidta_pkg::DIGIT_W-1:0]     digits [sidta_pkg::MAX_DIGITS];
  logic [sidta_pkg::CNT_W-1:0]       nd;
  logic [sidta_pkg::CNT_W-1:0]       cnt;
  logic [sidta_pkg::CNT_W-1:0]       cnt_less;
  logic                              neg;
  logic                              sign_pending;
  logic                              div_done;
  logic                              can_load;
  logic                              load;
  sidta_pkg::char_word_t             word;

  assign value_ready = (state == S_IDLE);
  assign accept      = value_valid && value_ready;

  // Unsigned magnitude; the most negative value maps to 2^31 without overflow.
  assign value_u = $unsigned(value);
  assign mag     = value_u[sidta_pkg::VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;

  // Digit extraction ends on a zero quotient or a full buffer.
  assign div_done = quot_zero || (nd == sidta_pkg::CNT_W'(sidta_pkg::MAX_DIGITS - 1));

  sidta_div10 u_div10 (
    .clk       (clk),
    .start     (accept),
    .mag       (mag),
    .prime     (state == S_MUL),
    .step      (state == S_DIV),
    .digit     (digit),
    .quot_zero (quot_zero)
  );

  // Character selection during emission: sign first, then digits from the top.
  assign cnt_less = cnt - 1'b1;
  assign load     = (state == S_EMIT) && can_load;

  always_comb begin
    if (sign_pending) begin
      word.char_code = sidta_pkg::CHAR_MINUS;
      word.last_char = 1'b0;
    end else begin
      word.char_code = sidta_pkg::CHAR_ZERO
                       + {4'b0000, digits[cnt_less[sidta_pkg::IDX_W-1:0]]};
      word.last_char = (cnt == sidta_pkg::CNT_W'(1));
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load && !sign_pending && (cnt == sidta_pkg::CNT_W'(1))) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Digit buffer, digit count and emission counters.
  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= value_u[sidta_pkg::VALUE_WIDTH-1];
      nd  <= '0;
    end
    if (state == S_DIV) begin
      digits[nd[sidta_pkg::IDX_W-1:0]] <= digit;
      nd <= nd + 1'b1;
      if (div_done) begin
        cnt          <= nd + 1'b1;
        sign_pending <= neg;
      end
    end
    if (load) begin
      if (sign_pending) begin
        sign_pending <= 1'b0;
      end else begin
        cnt <= cnt_less;
      end
    end
  end

  sidta_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .word       (word),
    .can_load   (can_load),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_code  (char_code),
    .last_char  (last_char)
  );

endmodule

`default_nettype wire

@@ rtl/sidta_checker.sv @@
// Port-level checks for the signed integer to decimal ASCII unit, bound to
// the top level. Depends on sidta_pkg for the value width.
`default_nettype none

module sidta_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              value_valid,
  input wire logic                              value_ready,
  input wire logic [sidta_pkg::VALUE_WIDTH-1:0] value,
  input wire logic                              char_valid,
  input wire logic                              char_ready,
  input wire logic [7:0]                        char_code,
  input wire logic                              last_char
);

  // Reset leaves the unit idle with an empty output.
  assert property (@(posedge clk) rst |=> value_ready && !char_valid)
    else $error("unit not idle after reset");

  // A taken value makes the unit busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    value_valid && value_ready |=> !value_ready)
    else $error("unit ready right after taking a value");

  // While a non-final character is shown, the number is still in progress.
  assert property (@(posedge clk) disable iff (rst)
    char_valid && !last_char |-> !value_ready)
    else $error("unit idle in the middle of a number");

  // A stalled character word holds.
  assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_ready |=> char_valid && $stable(char_code) && $stable(last_char))
    else $error("stalled character word changed");

endmodule

bind signed_int_to_decimal_ascii_unit sidta_checker u_sidta_checker (
  .clk         (clk),
  .rst         (rst),
  .value_valid (value_valid),
  .value_ready (value_ready),
  .value       (value),
  .char_valid  (char_valid),
  .char_ready  (char_ready),
  .char_code   (char_code),
  .last_char   (last_char)
);

`default_nettype wire

@@ sim/decimal_text_checker.sv @@
// Checker for the signed integer to decimal ASCII unit: watches both channels,
// predicts the character words of every accepted value and compares them.
// Depends on sidta_pkg for widths, character codes and the word type.
`timescale 1ns / 100ps

module decimal_text_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  value_valid,
  input  logic                                  value_ready,
  input  logic signed [sidta_pkg::VALUE_WIDTH-1:0] value,
  input  logic                                  char_valid,
  input  logic                                  char_ready,
  input  logic [7:0]                            char_code,
  input  logic                                  last_char,
  output int                                    mismatch_count,
  output int                                    chars_pending
);

  localparam int RADIX = 10;

  sidta_pkg::char_word_t expected_text[$];
  int                    mismatches = 0;
  int                    pending    = 0;

  assign mismatch_count = mismatches;
  assign chars_pending  = pending;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Appends the decimal text of one value to the expected character words.
  function automatic void push_decimal_text(input logic [sidta_pkg::VALUE_WIDTH-1:0] v);
    logic [sidta_pkg::VALUE_WIDTH-1:0] magnitude;
    logic [3:0]                        digits[sidta_pkg::MAX_DIGITS];
    int                                num_digits;
    sidta_pkg::char_word_t             w;
    // The magnitude is unsigned, so the most negative value does not overflow.
    magnitude  = v[sidta_pkg::VALUE_WIDTH-1] ? (~v + 1'b1) : v;
    num_digits = 0;
    do begin
      digits[num_digits] = 4'(magnitude % RADIX);
      magnitude          = magnitude / RADIX;
      num_digits++;
    end while (magnitude != 0 && num_digits < sidta_pkg::MAX_DIGITS);
    if (v[sidta_pkg::VALUE_WIDTH-1]) begin
      w.char_code = sidta_pkg::CHAR_MINUS;
      w.last_char = 1'b0;
      expected_text.push_back(w);
    end
    for (int i = num_digits - 1; i >= 0; i--) begin
      w.char_code = sidta_pkg::CHAR_ZERO + 8'(digits[i]);
      w.last_char = (i == 0);
      expected_text.push_back(w);
    end
  endfunction

  // Both channels are sampled at the rising edge.
  always @(posedge clk) begin
    sidta_pkg::char_word_t exp_word;
    if (!rst) begin
      if (value_valid && value_ready) begin
        push_decimal_text(value);
      end
      if (char_valid && char_ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected word char_code=%02h last_char=%0b",
                                    char_code, last_char));
        end else begin
          exp_word = expected_text.pop_front();
          if (char_code !== exp_word.char_code) begin
            report_mismatch($sformatf("char_code %02h, expected %02h",
                                      char_code, exp_word.char_code));
          end
          if (last_char !== exp_word.last_char) begin
            report_mismatch($sformatf("last_char %0b, expected %0b on char %02h",
                                      last_char, exp_word.last_char, exp_word.char_code));
          end
        end
      end
    end
    pending = expected_text.size();
  end

endmodule

@@ sim/tb_signed_int_to_decimal_ascii_unit.sv @@
// Testbench top for the signed integer to decimal ASCII unit: clock, reset,
// value stimulus in bursts and a stalling receiver. Depends on sidta_pkg,
// the unit itself and decimal_text_checker.
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii_unit;

  localparam int RANDOM_VALUES = 100;
  localparam int DRAIN_CYCLES  = 40;

  logic                                     clk = 1'b0;
  logic                                     rst;
  logic                                     value_valid;
  logic                                     value_ready;
  logic signed [sidta_pkg::VALUE_WIDTH-1:0] value;
  logic                                     char_valid;
  logic                                     char_ready;
  logic [7:0]                               char_code;
  logic                                     last_char;
  int                                       mismatch_count;
  int                                       chars_pending;
  logic [9:0]                               rx_cycle;
  logic [sidta_pkg::VALUE_WIDTH-1:0]        value_list[$];

  signed_int_to_decimal_ascii_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_code   (char_code),
    .last_char   (last_char)
  );

  decimal_text_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .value_valid    (value_valid),
    .value_ready    (value_ready),
    .value          (value),
    .char_valid     (char_valid),
    .char_ready     (char_ready),
    .char_code      (char_code),
    .last_char      (last_char),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  always #1 clk = ~clk;

  // Hard limit on the run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // The receiver cycles through full speed, random stalls, sparse acceptance
  // and short periodic stalls.
  always @(negedge clk) begin
    if (rst) begin
      rx_cycle   <= '0;
      char_ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1'b1;
      case (rx_cycle[9:8])
        2'd0: char_ready <= 1'b1;
        2'd1: char_ready <= 1'($urandom_range(0, 1));
        2'd2: char_ready <= ($urandom_range(0, 3) == 0);
        default: char_ready <= (rx_cycle[4:2] != 3'd0);
      endcase
    end
  end

  // Presents one value word and holds it until the unit takes it.
  task automatic send_value(input logic [sidta_pkg::VALUE_WIDTH-1:0] v);
    @(negedge clk);
    value_valid <= 1'b1;
    value       <= v;
    do @(posedge clk); while (!value_ready);
  endtask

  // Drops valid for a number of cycles, with noise on the payload.
  task automatic idle_gap(input int cycles);
    @(negedge clk);
    value_valid <= 1'b0;
    value       <= $urandom;
    repeat (cycles - 1) @(posedge clk);
  endtask

  // Draws any word, a value near the extremes, or a random-length magnitude.
  function automatic logic [sidta_pkg::VALUE_WIDTH-1:0] random_value();
    longint magnitude;
    int     num_digits;
    int     kind;
    kind       = $urandom_range(0, 9);
    num_digits = $urandom_range(1, sidta_pkg::MAX_DIGITS);
    if (kind < 2) begin
      return $urandom;
    end else if (kind == 2) begin
      // Near the two extremes.
      magnitude = 64'd2147483648 - $urandom_range(0, 3);
    end else if (num_digits == sidta_pkg::MAX_DIGITS) begin
      magnitude = $urandom_range(1000000000, 2147483647);
    end else begin
      magnitude = $urandom_range(0, (10 ** num_digits) - 1);
    end
    if ($urandom_range(0, 1)) begin
      magnitude = -magnitude;
    end
    return magnitude[sidta_pkg::VALUE_WIDTH-1:0];
  endfunction

  initial begin
    int burst_left;
    logic [sidta_pkg::VALUE_WIDTH-1:0] v;
    rst         = 1'b1;
    value_valid = 1'b0;
    value       = '0;

    // Directed values: zero, single digits, powers of ten, both extremes.
    value_list = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10,
                   32'd99, 32'd100, 32'd12345, -32'sd12345, 32'd999999999,
                   32'd1000000000, -32'sd1000000000, 32'h7FFF_FFFF,
                   32'h8000_0001, 32'h8000_0000, 32'd1234567890,
                   -32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7};
    repeat (RANDOM_VALUES) value_list.push_back(random_value());

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Bursts of random length, with a long stretch of back-to-back words.
    burst_left = 0;
    foreach (value_list[i]) begin
      if (burst_left == 0) begin
        if (i > 0) begin
          idle_gap($urandom_range(1, 30));
        end
        burst_left = (i > 40 && i < 70) ? 30 : $urandom_range(1, 8);
      end
      v = value_list[i];
      send_value(v);
      burst_left--;
    end
    @(negedge clk);
    value_valid <= 1'b0;

    wait (chars_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/sidta_pkg.sv
rtl/sidta_div10.sv
rtl/sidta_out_reg.sv
rtl/signed_int_to_decimal_ascii_unit.sv
rtl/sidta_checker.sv
sim/decimal_text_checker.sv
sim/tb_signed_int_to_decimal_ascii_unit.sv
